// ----- rtl/mclp_pkg.sv -----
// Shared types, character codes and result codes for the motor command line parser.
// Used by the channel interfaces, the line scanner, the line judge and the top level.
// Depends on nothing.
package mclp_pkg;

   localparam int BYTE_W  = 8;
   localparam int MAG_W   = 16;
   localparam int LIMIT_W = 15;
   localparam int PWM_W   = 16;
   localparam int ERR_W   = 3;
   localparam int CMD_W   = 2;
   localparam int CHAN_W  = 2;
   localparam int TOK_W   = 3;
   localparam int PFX_W   = 3;
   localparam int PHASE_W = 2;

   // Character codes.
   localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
   localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
   localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
   localparam logic [BYTE_W-1:0] CH_E     = 8'h45;
   localparam logic [BYTE_W-1:0] CH_M     = 8'h4D;
   localparam logic [BYTE_W-1:0] CH_O     = 8'h4F;
   localparam logic [BYTE_W-1:0] CH_P     = 8'h50;
   localparam logic [BYTE_W-1:0] CH_S     = 8'h53;
   localparam logic [BYTE_W-1:0] CH_T     = 8'h54;
   localparam logic [BYTE_W-1:0] CH_WS_LO = 8'h09;
   localparam logic [BYTE_W-1:0] CH_WS_HI = 8'h0D;

   // Error codes.
   localparam logic [ERR_W-1:0] ERR_BAD_PREFIX  = 3'd0;
   localparam logic [ERR_W-1:0] ERR_ARG_COUNT   = 3'd1;
   localparam logic [ERR_W-1:0] ERR_BAD_CHANNEL = 3'd2;
   localparam logic [ERR_W-1:0] ERR_PARSE_INT   = 3'd3;
   localparam logic [ERR_W-1:0] ERR_RANGE       = 3'd4;
   localparam logic [ERR_W-1:0] ERR_OVERLONG    = 3'd5;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_STOP    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ENCODER = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DRIVE   = 2'd2;

   // Progress through the first token of a line.
   localparam logic [PFX_W-1:0] PFX_EMPTY = 3'd0;
   localparam logic [PFX_W-1:0] PFX_S     = 3'd1;
   localparam logic [PFX_W-1:0] PFX_ST    = 3'd2;
   localparam logic [PFX_W-1:0] PFX_STO   = 3'd3;
   localparam logic [PFX_W-1:0] PFX_STOP  = 3'd4;
   localparam logic [PFX_W-1:0] PFX_E     = 3'd5;
   localparam logic [PFX_W-1:0] PFX_M     = 3'd6;
   localparam logic [PFX_W-1:0] PFX_BAD   = 3'd7;

   // Number scanner phases.
   localparam logic [PHASE_W-1:0] NUM_LEAD   = 2'd0;
   localparam logic [PHASE_W-1:0] NUM_SIGN   = 2'd1;
   localparam logic [PHASE_W-1:0] NUM_DIGITS = 2'd2;
   localparam logic [PHASE_W-1:0] NUM_BAD    = 2'd3;

   // Token counts: the count saturates once a token beyond any command is seen.
   localparam logic [TOK_W-1:0] TOK_NONE   = 3'd0;
   localparam logic [TOK_W-1:0] TOK_PREFIX = 3'd1;
   localparam logic [TOK_W-1:0] TOK_CHAN   = 3'd2;
   localparam logic [TOK_W-1:0] TOK_PWM    = 3'd3;
   localparam logic [TOK_W-1:0] TOK_MAX    = 3'd4;

   localparam logic [MAG_W-1:0]   MAG_MAX         = 16'hFFFF;
   localparam logic [LIMIT_W-1:0] PWM_LIMIT_RESET = 15'd1000;

   typedef struct packed {
      logic               has_content;
      logic               in_token;
      logic [TOK_W-1:0]   tok_cnt;
      logic [PFX_W-1:0]   prefix;
      logic [PHASE_W-1:0] num_phase;
      logic               num_neg;
      logic [MAG_W-1:0]   num_mag;
      logic               chan_ok;
      logic [CHAN_W-1:0]  chan;
      logic               pwm_ok;
      logic               pwm_neg;
      logic [MAG_W-1:0]   pwm_mag;
   } parse_state_type;

   localparam parse_state_type PARSE_IDLE = '0;

   typedef struct packed {
      logic                    is_error;
      logic [ERR_W-1:0]        error_code;
      logic [CMD_W-1:0]        command_type;
      logic [CHAN_W-1:0]       channel;
      logic signed [PWM_W-1:0] pwm;
   } result_type;

   // A channel number is good when it is an unsigned or plus-signed 1 to 4.
   function automatic logic chan_valid(input logic [PHASE_W-1:0] phase,
                                       input logic neg,
                                       input logic [MAG_W-1:0] mag);
      return (phase == NUM_DIGITS) && !neg && (mag >= 16'd1) && (mag <= 16'd4);
   endfunction

   function automatic logic [CHAN_W-1:0] chan_index(input logic [MAG_W-1:0] mag);
      return CHAN_W'(mag[CHAN_W-1:0] - 2'd1);
   endfunction

endpackage

// ----- rtl/mclp_if.sv -----
// Valid/ready channel interfaces for received bytes and parse results.
// Depends on mclp_pkg for field widths and the result layout.
interface mclp_req_if;
   logic                          valid;
   logic                          ready;
   logic [mclp_pkg::BYTE_W-1:0]   rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface mclp_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                is_error;
   logic [mclp_pkg::ERR_W-1:0]          error_code;
   logic [mclp_pkg::CMD_W-1:0]          command_type;
   logic [mclp_pkg::CHAN_W-1:0]         channel;
   logic signed [mclp_pkg::PWM_W-1:0]   pwm;

   modport source (output valid, output is_error, output error_code, output command_type,
                   output channel, output pwm, input ready);
   modport sink (input valid, input is_error, input error_code, input command_type,
                 input channel, input pwm, output ready);
endinterface

// ----- rtl/mclp_scanner.sv -----
// Line scanner: folds each received byte into a compact summary of the current line.
// Depends on mclp_pkg for the character codes and the parse state layout.
module mclp_scanner #(
   parameter int LINE_BYTES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [mclp_pkg::BYTE_W-1:0]   rx_byte,
   input  logic                          advance,
   output logic                          overflow,
   output mclp_pkg::parse_state_type     status
);

   localparam int CNT_W = $clog2(LINE_BYTES);

   mclp_pkg::parse_state_type parse_ff, parse_in, replay;
   logic             pending_ff, pending_in;
   logic             trunc_ff, trunc_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             is_cr, is_lf, is_stored, at_limit, is_trim_ws;

   // Applies one committed (non-trailing) byte to the line summary.
   function automatic mclp_pkg::parse_state_type consume(
      input mclp_pkg::parse_state_type s,
      input logic [mclp_pkg::BYTE_W-1:0] c);
      mclp_pkg::parse_state_type n;
      logic        is_digit;
      logic        is_ws;
      logic [3:0]  dval;
      logic [19:0] acc;
      n = s;
      is_digit = (c >= mclp_pkg::CH_ZERO) && (c <= mclp_pkg::CH_NINE);
      is_ws = (c == mclp_pkg::CH_SPACE) ||
              ((c >= mclp_pkg::CH_WS_LO) && (c <= mclp_pkg::CH_WS_HI));
      dval = 4'(c - mclp_pkg::CH_ZERO);
      n.has_content = 1'b1;
      if (c == mclp_pkg::CH_COMMA) begin
         n.in_token = 1'b0;
      end else begin
         if (!s.in_token) begin
            // A new token begins; the finished one is summarized if it matters later.
            n.in_token = 1'b1;
            if (s.tok_cnt == mclp_pkg::TOK_CHAN) begin
               n.chan_ok = mclp_pkg::chan_valid(s.num_phase, s.num_neg, s.num_mag);
               n.chan    = mclp_pkg::chan_index(s.num_mag);
            end
            if (s.tok_cnt == mclp_pkg::TOK_PWM) begin
               n.pwm_ok  = (s.num_phase == mclp_pkg::NUM_DIGITS);
               n.pwm_neg = s.num_neg;
               n.pwm_mag = s.num_mag;
            end
            if (s.tok_cnt != mclp_pkg::TOK_MAX) begin
               n.tok_cnt = s.tok_cnt + 3'd1;
            end
            n.num_phase = mclp_pkg::NUM_LEAD;
            n.num_neg   = 1'b0;
            n.num_mag   = '0;
         end

         if (n.tok_cnt == mclp_pkg::TOK_PREFIX) begin
            unique case (n.prefix)
               mclp_pkg::PFX_EMPTY: begin
                  if (c == mclp_pkg::CH_S) begin
                     n.prefix = mclp_pkg::PFX_S;
                  end else if (c == mclp_pkg::CH_E) begin
                     n.prefix = mclp_pkg::PFX_E;
                  end else if (c == mclp_pkg::CH_M) begin
                     n.prefix = mclp_pkg::PFX_M;
                  end else begin
                     n.prefix = mclp_pkg::PFX_BAD;
                  end
               end
               mclp_pkg::PFX_S: begin
                  n.prefix = (c == mclp_pkg::CH_T) ? mclp_pkg::PFX_ST : mclp_pkg::PFX_BAD;
               end
               mclp_pkg::PFX_ST: begin
                  n.prefix = (c == mclp_pkg::CH_O) ? mclp_pkg::PFX_STO : mclp_pkg::PFX_BAD;
               end
               mclp_pkg::PFX_STO: begin
                  n.prefix = (c == mclp_pkg::CH_P) ? mclp_pkg::PFX_STOP : mclp_pkg::PFX_BAD;
               end
               default: begin
                  n.prefix = mclp_pkg::PFX_BAD;
               end
            endcase
         end

         acc = ({4'b0, n.num_mag} << 3) + ({4'b0, n.num_mag} << 1) + 20'(dval);
         case (n.num_phase)
            mclp_pkg::NUM_LEAD: begin
               if (is_ws) begin
                  n.num_phase = mclp_pkg::NUM_LEAD;
               end else if ((c == mclp_pkg::CH_PLUS) || (c == mclp_pkg::CH_MINUS)) begin
                  n.num_phase = mclp_pkg::NUM_SIGN;
                  n.num_neg   = (c == mclp_pkg::CH_MINUS);
               end else if (is_digit) begin
                  n.num_phase = mclp_pkg::NUM_DIGITS;
                  n.num_mag   = 16'(dval);
               end else begin
                  n.num_phase = mclp_pkg::NUM_BAD;
               end
            end
            mclp_pkg::NUM_SIGN: begin
               if (is_digit) begin
                  n.num_phase = mclp_pkg::NUM_DIGITS;
                  n.num_mag   = 16'(dval);
               end else begin
                  n.num_phase = mclp_pkg::NUM_BAD;
               end
            end
            mclp_pkg::NUM_DIGITS: begin
               if (is_digit) begin
                  n.num_mag = (acc > 20'(mclp_pkg::MAG_MAX)) ? mclp_pkg::MAG_MAX : acc[15:0];
               end else begin
                  n.num_phase = mclp_pkg::NUM_BAD;
               end
            end
            default: begin
               n.num_phase = mclp_pkg::NUM_BAD;
            end
         endcase
      end
      return n;
   endfunction

   assign is_cr      = (rx_byte == mclp_pkg::CH_CR);
   assign is_lf      = (rx_byte == mclp_pkg::CH_LF);
   assign is_stored  = !is_cr && !is_lf;
   assign at_limit   = (count_ff == CNT_W'(LINE_BYTES - 1));
   assign is_trim_ws = (rx_byte == mclp_pkg::CH_SPACE) || (rx_byte == mclp_pkg::CH_TAB);
   assign overflow   = is_stored && at_limit;
   assign status     = parse_ff;

   // Spaces and tabs are held back as pending: they only count once a later
   // byte shows they are not trailing, and then one of them stands for all.
   assign replay = consume(parse_ff, mclp_pkg::CH_SPACE);

   always_comb begin
      parse_in   = parse_ff;
      pending_in = pending_ff;
      trunc_in   = trunc_ff;
      count_in   = count_ff;
      if (advance) begin
         if (is_lf || overflow) begin
            parse_in   = mclp_pkg::PARSE_IDLE;
            pending_in = 1'b0;
            trunc_in   = 1'b0;
            count_in   = '0;
         end else if (is_stored) begin
            count_in = count_ff + 1'b1;
            if (!trunc_ff) begin
               if (rx_byte == mclp_pkg::CH_NUL) begin
                  trunc_in = 1'b1;
               end else if (is_trim_ws) begin
                  pending_in = 1'b1;
               end else begin
                  parse_in   = consume(pending_ff ? replay : parse_ff, rx_byte);
                  pending_in = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parse_ff   <= mclp_pkg::PARSE_IDLE;
         pending_ff <= 1'b0;
         trunc_ff   <= 1'b0;
         count_ff   <= '0;
      end else begin
         parse_ff   <= parse_in;
         pending_ff <= pending_in;
         trunc_ff   <= trunc_in;
         count_ff   <= count_in;
      end
   end

endmodule

// ----- rtl/mclp_judge.sv -----
// Line judge: turns the summary of a finished line into a command or an error result.
// Depends on mclp_pkg for the parse state, the result layout and the codes.
module mclp_judge (
   input  mclp_pkg::parse_state_type        status,
   input  logic [mclp_pkg::LIMIT_W-1:0]     pwm_limit,
   output mclp_pkg::result_type             result
);

   logic                        chan_ok;
   logic [mclp_pkg::CHAN_W-1:0] chan;
   logic                        pwm_ok;
   logic                        pwm_neg;
   logic [mclp_pkg::MAG_W-1:0]  pwm_mag;

   // The last token seen may still sit in the live number scanner.
   always_comb begin
      if (status.tok_cnt == mclp_pkg::TOK_CHAN) begin
         chan_ok = mclp_pkg::chan_valid(status.num_phase, status.num_neg, status.num_mag);
         chan    = mclp_pkg::chan_index(status.num_mag);
      end else begin
         chan_ok = status.chan_ok;
         chan    = status.chan;
      end
      if (status.tok_cnt == mclp_pkg::TOK_PWM) begin
         pwm_ok  = (status.num_phase == mclp_pkg::NUM_DIGITS);
         pwm_neg = status.num_neg;
         pwm_mag = status.num_mag;
      end else begin
         pwm_ok  = status.pwm_ok;
         pwm_neg = status.pwm_neg;
         pwm_mag = status.pwm_mag;
      end
   end

   always_comb begin
      result = '0;
      if (status.tok_cnt == mclp_pkg::TOK_NONE) begin
         // The line held nothing but commas.
         result.is_error   = 1'b1;
         result.error_code = mclp_pkg::ERR_BAD_PREFIX;
      end else begin
         unique case (status.prefix) inside
            mclp_pkg::PFX_STOP: begin
               if (status.tok_cnt >= mclp_pkg::TOK_CHAN) begin
                  result.is_error   = 1'b1;
                  result.error_code = mclp_pkg::ERR_ARG_COUNT;
               end else begin
                  result.command_type = mclp_pkg::CMD_STOP;
               end
            end
            mclp_pkg::PFX_E, mclp_pkg::PFX_M: begin
               if ((status.tok_cnt < mclp_pkg::TOK_CHAN) || !chan_ok) begin
                  result.is_error   = 1'b1;
                  result.error_code = mclp_pkg::ERR_BAD_CHANNEL;
               end else if (status.prefix == mclp_pkg::PFX_E) begin
                  if (status.tok_cnt >= mclp_pkg::TOK_PWM) begin
                     result.is_error   = 1'b1;
                     result.error_code = mclp_pkg::ERR_ARG_COUNT;
                  end else begin
                     result.command_type = mclp_pkg::CMD_ENCODER;
                     result.channel      = chan;
                  end
               end else if (status.tok_cnt < mclp_pkg::TOK_PWM) begin
                  result.is_error   = 1'b1;
                  result.error_code = mclp_pkg::ERR_ARG_COUNT;
               end else if (!pwm_ok) begin
                  result.is_error   = 1'b1;
                  result.error_code = mclp_pkg::ERR_PARSE_INT;
               end else if (pwm_mag > {1'b0, pwm_limit}) begin
                  result.is_error   = 1'b1;
                  result.error_code = mclp_pkg::ERR_RANGE;
               end else if (status.tok_cnt >= mclp_pkg::TOK_MAX) begin
                  result.is_error   = 1'b1;
                  result.error_code = mclp_pkg::ERR_ARG_COUNT;
               end else begin
                  result.command_type = mclp_pkg::CMD_DRIVE;
                  result.channel      = chan;
                  result.pwm          = pwm_neg ? (~pwm_mag + 16'd1) : pwm_mag;
               end
            end
            default: begin
               result.is_error   = 1'b1;
               result.error_code = mclp_pkg::ERR_BAD_PREFIX;
            end
         endcase
      end
   end

endmodule

// ----- rtl/motor_command_line_parser.sv -----
// Motor command line parser top level: byte holding register, scanner, judge, result register.
// Depends on mclp_pkg, mclp_req_if/mclp_rsp_if, mclp_scanner and mclp_judge.
//
// Received bytes come in on req_bus, one per transaction, and each completed
// line leaves as at most one transaction on rsp_bus: STOP, E,<ch> or
// M,<ch>,<pwm>, or an error code. CR is dropped, LF ends a line, and a line
// longer than LINE_BYTES-1 stored bytes gives an overlong-line error at once
// and starts over. csr_wr_en/csr_wr_data write the pwm limit; write it only
// while no line is being received.
// Throughput is one byte per cycle, save that a line-ending byte waits while a
// result is still held: the line is summarized as it arrives, so an LF is judged
// in the same cycle as any other byte. The LF waits in the byte holding register
// until the result register is free and is then judged straight into it, which
// raises rsp_bus.valid.
// While a result waits for rsp_bus.ready, bytes that end no line keep flowing;
// a byte that would produce a second result waits in the holding register.
// Reset is synchronous: it empties both registers, clears the line and sets
// the pwm limit to 1000.
module motor_command_line_parser #(
   parameter int LINE_BYTES = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   mclp_req_if.sink                        req_bus,
   mclp_rsp_if.source                      rsp_bus,
   input  logic                            csr_wr_en,
   input  logic [mclp_pkg::LIMIT_W-1:0]    csr_wr_data
);

   logic                            hold_valid_ff, hold_valid_in;
   logic [mclp_pkg::BYTE_W-1:0]     hold_byte_ff, hold_byte_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   mclp_pkg::result_type            rsp_data_ff, rsp_data_in;
   logic [mclp_pkg::LIMIT_W-1:0]    pwm_limit_ff, pwm_limit_in;

   mclp_pkg::parse_state_type       status;
   mclp_pkg::result_type            judged;
   mclp_pkg::result_type            too_long;
   logic                            overflow;
   logic                            will_emit;
   logic                            out_free;
   logic                            advance;
   logic                            accept;
   logic                            emit;

   mclp_scanner #(
      .LINE_BYTES (LINE_BYTES)
   ) u_scanner (
      .clock    (clock),
      .reset    (reset),
      .rx_byte  (hold_byte_ff),
      .advance  (advance),
      .overflow (overflow),
      .status   (status)
   );

   mclp_judge u_judge (
      .status    (status),
      .pwm_limit (pwm_limit_ff),
      .result    (judged)
   );

   always_comb begin
      too_long            = '0;
      too_long.is_error   = 1'b1;
      too_long.error_code = mclp_pkg::ERR_OVERLONG;
   end

   assign will_emit = ((hold_byte_ff == mclp_pkg::CH_LF) && status.has_content) || overflow;
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign advance   = hold_valid_ff && (!will_emit || out_free);
   assign emit      = advance && will_emit;
   assign req_bus.ready = !hold_valid_ff || advance;
   assign accept    = req_bus.valid && req_bus.ready;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_byte_in  = hold_byte_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
         hold_byte_in  = req_bus.rx_byte;
      end else if (advance) begin
         hold_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = overflow ? too_long : judged;
      end

      pwm_limit_in = csr_wr_en ? csr_wr_data : pwm_limit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pwm_limit_ff  <= mclp_pkg::PWM_LIMIT_RESET;
      end else begin
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         pwm_limit_ff  <= pwm_limit_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_byte_ff <= hold_byte_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.is_error     = rsp_data_ff.is_error;
   assign rsp_bus.error_code   = rsp_data_ff.error_code;
   assign rsp_bus.command_type = rsp_data_ff.command_type;
   assign rsp_bus.channel      = rsp_data_ff.channel;
   assign rsp_bus.pwm          = rsp_data_ff.pwm;

endmodule

// ----- sim/tb.sv -----
// Self-checking bench for motor_command_line_parser: byte stream in, at most one verdict per line out.
// It needs mclp_pkg, the mclp_req_if/mclp_rsp_if interfaces and the parser RTL, nothing else.
`timescale 1ns / 1ps

module tb;

   localparam int LINE_BYTES   = 64;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE_TICKS = 4;
   localparam int LONG_HOLD    = 300;
   localparam mclp_pkg::result_type NO_VERDICT = '0;
   localparam logic [mclp_pkg::BYTE_W-1:0] NO_FILL = mclp_pkg::CH_NUL;

   typedef struct {
      string                       head;
      int                          fill_count;
      logic [mclp_pkg::BYTE_W-1:0] fill_byte;
      string                       tail;
      bit                          typed;
      mclp_pkg::result_type        want;
   } drill_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [mclp_pkg::LIMIT_W-1:0] csr_wr_data;

   mclp_req_if req_bus();
   mclp_rsp_if rsp_bus();

   motor_command_line_parser #(.LINE_BYTES(LINE_BYTES)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Line predictor state, kept apart from the block.
   logic [mclp_pkg::BYTE_W-1:0]  line_store [LINE_BYTES-1];
   int                           line_len = 0;
   logic [mclp_pkg::LIMIT_W-1:0] limit_model = mclp_pkg::PWM_LIMIT_RESET;

   mclp_pkg::result_type        line_verdicts [$];
   logic [mclp_pkg::BYTE_W-1:0] out_line [$];
   drill_type                   drills [$];

   int bytes_sent     = 0;
   int fault_count    = 0;
   int commands_seen  = 0;
   int errors_seen    = 0;
   int cycle_count    = 0;
   int idle_odds      = 0;
   int stall_odds     = 0;
   int hold_cycles    = 0;
   int middle_limit   = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic mclp_pkg::result_type cmd_result(
      input logic [mclp_pkg::CMD_W-1:0] kind,
      input logic [mclp_pkg::CHAN_W-1:0] ch,
      input logic signed [mclp_pkg::PWM_W-1:0] pwm);
      mclp_pkg::result_type r;
      r = '0;
      r.command_type = kind;
      r.channel = ch;
      r.pwm = pwm;
      return r;
   endfunction

   function automatic mclp_pkg::result_type err_result(
      input logic [mclp_pkg::ERR_W-1:0] code);
      mclp_pkg::result_type r;
      r = '0;
      r.is_error = 1'b1;
      r.error_code = code;
      return r;
   endfunction

   // Skips a run of commas, then spans one field up to the next comma or the end.
   function automatic bit next_field(inout int pos, input int len, output int s, output int e);
      s = 0;
      e = 0;
      while (pos < len && line_store[pos] == mclp_pkg::CH_COMMA) pos++;
      if (pos >= len) return 1'b0;
      s = pos;
      while (pos < len && line_store[pos] != mclp_pkg::CH_COMMA) pos++;
      e = pos;
      return 1'b1;
   endfunction

   // The whole field must be: blanks, an optional sign, then at least one digit.
   function automatic bit read_number(input int s, input int e, output int val);
      int p, mag, digits;
      bit neg;
      p = s;
      mag = 0;
      digits = 0;
      neg = 1'b0;
      val = 0;
      while (p < e && (line_store[p] == mclp_pkg::CH_SPACE ||
                       (line_store[p] >= mclp_pkg::CH_WS_LO &&
                        line_store[p] <= mclp_pkg::CH_WS_HI))) p++;
      if (p < e && (line_store[p] == mclp_pkg::CH_PLUS ||
                    line_store[p] == mclp_pkg::CH_MINUS)) begin
         neg = (line_store[p] == mclp_pkg::CH_MINUS);
         p++;
      end
      while (p < e && line_store[p] >= mclp_pkg::CH_ZERO &&
             line_store[p] <= mclp_pkg::CH_NINE) begin
         mag = mag * 10 + int'(line_store[p] - mclp_pkg::CH_ZERO);
         if (mag > 65535) mag = 65535;
         digits++;
         p++;
      end
      if (digits == 0 || p != e) return 1'b0;
      val = neg ? -mag : mag;
      return 1'b1;
   endfunction

   function automatic bit judge_line(input int len, output mclp_pkg::result_type r);
      int n, pos, s, e, ch, pwm, lim;
      bit is_drive;
      r = '0;
      n = 0;
      pos = 0;
      lim = int'(limit_model);
      while (n < len && line_store[n] != mclp_pkg::CH_NUL) n++;
      while (n > 0 && (line_store[n-1] == mclp_pkg::CH_CR ||
                       line_store[n-1] == mclp_pkg::CH_LF ||
                       line_store[n-1] == mclp_pkg::CH_SPACE ||
                       line_store[n-1] == mclp_pkg::CH_TAB)) n--;
      if (n == 0) return 1'b0;
      if (!next_field(pos, n, s, e)) begin
         r = err_result(mclp_pkg::ERR_BAD_PREFIX);
         return 1'b1;
      end
      if (e - s == 4 && line_store[s] == mclp_pkg::CH_S && line_store[s+1] == mclp_pkg::CH_T &&
          line_store[s+2] == mclp_pkg::CH_O && line_store[s+3] == mclp_pkg::CH_P) begin
         if (next_field(pos, n, s, e)) r = err_result(mclp_pkg::ERR_ARG_COUNT);
         else r = cmd_result(mclp_pkg::CMD_STOP, '0, '0);
         return 1'b1;
      end
      if (e - s == 1 && (line_store[s] == mclp_pkg::CH_E || line_store[s] == mclp_pkg::CH_M))
      begin
         is_drive = (line_store[s] == mclp_pkg::CH_M);
         if (!next_field(pos, n, s, e)) begin
            r = err_result(mclp_pkg::ERR_BAD_CHANNEL);
            return 1'b1;
         end
         if (!read_number(s, e, ch) || ch < 1 || ch > 4) begin
            r = err_result(mclp_pkg::ERR_BAD_CHANNEL);
            return 1'b1;
         end
         pwm = 0;
         if (is_drive) begin
            if (!next_field(pos, n, s, e)) begin
               r = err_result(mclp_pkg::ERR_ARG_COUNT);
               return 1'b1;
            end
            if (!read_number(s, e, pwm)) begin
               r = err_result(mclp_pkg::ERR_PARSE_INT);
               return 1'b1;
            end
            if (pwm < -lim || pwm > lim) begin
               r = err_result(mclp_pkg::ERR_RANGE);
               return 1'b1;
            end
         end
         if (next_field(pos, n, s, e)) begin
            r = err_result(mclp_pkg::ERR_ARG_COUNT);
            return 1'b1;
         end
         r = cmd_result(is_drive ? mclp_pkg::CMD_DRIVE : mclp_pkg::CMD_ENCODER,
                        mclp_pkg::CHAN_W'(ch - 1), mclp_pkg::PWM_W'(pwm));
         return 1'b1;
      end
      r = err_result(mclp_pkg::ERR_BAD_PREFIX);
      return 1'b1;
   endfunction

   // Advances the line predictor by one received byte; returns 1 when a verdict is due.
   function automatic bit judge_byte(input logic [mclp_pkg::BYTE_W-1:0] b,
                                     output mclp_pkg::result_type r);
      int held;
      r = '0;
      if (b == mclp_pkg::CH_CR) return 1'b0;
      if (b == mclp_pkg::CH_LF) begin
         held = line_len;
         line_len = 0;
         return judge_line(held, r);
      end
      if (line_len < LINE_BYTES - 1) begin
         line_store[line_len] = b;
         line_len++;
         return 1'b0;
      end
      line_len = 0;
      r = err_result(mclp_pkg::ERR_OVERLONG);
      return 1'b1;
   endfunction

   function automatic void put_text(input string text);
      for (int i = 0; i < text.len(); i++) out_line.push_back(text[i]);
   endfunction

   function automatic void put_commas();
      repeat (($urandom_range(0, 4) == 0) ? $urandom_range(2, 3) : 1)
         out_line.push_back(mclp_pkg::CH_COMMA);
   endfunction

   function automatic void put_number(input int v);
      if ($urandom_range(0, 7) == 0) begin
         case ($urandom_range(0, 3))
            0: out_line.push_back(mclp_pkg::CH_SPACE);
            1: out_line.push_back(mclp_pkg::CH_TAB);
            2: out_line.push_back(8'h0B);
            default: out_line.push_back(8'h0C);
         endcase
      end
      if (v >= 0 && $urandom_range(0, 7) == 0) out_line.push_back(mclp_pkg::CH_PLUS);
      if (v >= 0 && $urandom_range(0, 9) == 0) out_line.push_back(mclp_pkg::CH_ZERO);
      put_text($sformatf("%0d", v));
   endfunction

   function automatic int pick_channel();
      case ($urandom_range(0, 9))
         0: return int'($urandom_range(0, 9)) - 1;
         1: return 65536 + int'($urandom_range(0, 9));
         default: return int'($urandom_range(1, 4));
      endcase
   endfunction

   function automatic int pick_pwm(input int lim);
      case ($urandom_range(0, 11))
         0: return lim;
         1: return -lim;
         2: return lim + 1;
         3: return -lim - 1;
         4: return 0;
         5: return int'($urandom_range(0, 65535)) - 32768;
         6: return 65535 + int'($urandom_range(0, 999999));
         default: return int'($urandom_range(0, 2 * lim)) - lim;
      endcase
   endfunction

   // Mostly well-formed command lines with random content; the rest is noise,
   // overlong lines and broken skeletons.
   function automatic void build_random_line();
      int pick, lim;
      lim = int'(limit_model);
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) put_commas();
      if (pick < 12) begin
         put_text("STOP");
      end else if (pick < 35) begin
         put_text("E");
         put_commas();
         put_number(pick_channel());
      end else if (pick < 75) begin
         put_text("M");
         put_commas();
         put_number(pick_channel());
         put_commas();
         put_number(pick_pwm(lim));
      end else if (pick < 86) begin
         repeat ($urandom_range(0, 12))
            out_line.push_back(mclp_pkg::BYTE_W'($urandom_range(0, 255)));
      end else if (pick < 89) begin
         repeat ($urandom_range(LINE_BYTES - 8, LINE_BYTES + 10))
            out_line.push_back(mclp_pkg::BYTE_W'($urandom_range(8'h21, 8'h7E)));
      end else begin
         case ($urandom_range(0, 5))
            0: put_text("M");
            1: begin
               put_text("M,");
               put_number(pick_channel());
            end
            2: put_text("E,,");
            3: put_text("Stop");
            4: put_text("ME,1");
            default: put_text("STOPS");
         endcase
      end
      if ($urandom_range(0, 11) == 0) begin
         put_commas();
         put_number(int'($urandom_range(0, 9)));
      end
      if (out_line.size() != 0 && $urandom_range(0, 9) == 0)
         out_line[$urandom_range(0, out_line.size() - 1)] =
            mclp_pkg::BYTE_W'($urandom_range(0, 255));
      if ($urandom_range(0, 19) == 0)
         out_line.insert($urandom_range(0, out_line.size()), mclp_pkg::CH_CR);
      if ($urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(0, 2))
               0: out_line.push_back(mclp_pkg::CH_SPACE);
               1: out_line.push_back(mclp_pkg::CH_TAB);
               default: out_line.push_back(mclp_pkg::CH_CR);
            endcase
         end
      end
      out_line.push_back(mclp_pkg::CH_LF);
   endfunction

   task automatic send_byte(input logic [mclp_pkg::BYTE_W-1:0] b, input bit record);
      mclp_pkg::result_type r;
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.rx_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      if (b != mclp_pkg::CH_CR) bytes_sent++;
      if (judge_byte(b, r) && record) line_verdicts.push_back(r);
   endtask

   task automatic send_line(input bit record);
      foreach (out_line[i]) send_byte(out_line[i], record);
      out_line.delete();
   endtask

   // Stops offering bytes and waits until every awaited verdict has come back.
   task automatic settle();
      if (req_bus.valid !== 1'b0) req_bus.valid <= 1'b0;
      while (line_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_pwm_limit(input logic [mclp_pkg::LIMIT_W-1:0] value);
      settle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      limit_model = value;
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_phase(input int budget, input bit calm);
      int stop_at;
      stop_at = bytes_sent + budget;
      idle_odds = (calm || $urandom_range(0, 4) == 0) ? 0 : $urandom_range(3, 10);
      stall_odds = (calm || $urandom_range(0, 4) == 0) ? 0 : $urandom_range(3, 10);
      while (bytes_sent < stop_at) begin
         build_random_line();
         send_line(1'b1);
      end
      settle();
   endtask

   // Result side: random back-pressure bursts, plus one long hold on request.
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
            rsp_bus.ready <= 1'b1;
         end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Every result transaction is held against the oldest awaited verdict.
   always @(posedge clock) begin : watch_results
      mclp_pkg::result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (rsp_bus.is_error) errors_seen++;
         else commands_seen++;
         if (line_verdicts.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
               $display("tb: unexpected result err=%0d code=%0d cmd=%0d ch=%0d pwm=%0d",
                        rsp_bus.is_error, rsp_bus.error_code, rsp_bus.command_type,
                        rsp_bus.channel, rsp_bus.pwm);
         end else begin
            want = line_verdicts.pop_front();
            if (rsp_bus.is_error !== want.is_error || rsp_bus.error_code !== want.error_code ||
                rsp_bus.command_type !== want.command_type ||
                rsp_bus.channel !== want.channel || rsp_bus.pwm !== want.pwm) begin
               fault_count++;
               if (fault_count <= 10) begin
                  $display("tb: mismatch want err=%0d code=%0d cmd=%0d ch=%0d pwm=%0d",
                           want.is_error, want.error_code, want.command_type,
                           want.channel, want.pwm);
                  $display("tb:           got err=%0d code=%0d cmd=%0d ch=%0d pwm=%0d",
                           rsp_bus.is_error, rsp_bus.error_code, rsp_bus.command_type,
                           rsp_bus.channel, rsp_bus.pwm);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   initial begin
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.rx_byte <= '0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;

      drills.push_back('{"STOP\n", 0, NO_FILL, "", 1'b1,
                         cmd_result(mclp_pkg::CMD_STOP, 2'd0, 16'sd0)});
      drills.push_back('{"E,1\n", 0, NO_FILL, "", 1'b1,
                         cmd_result(mclp_pkg::CMD_ENCODER, 2'd0, 16'sd0)});
      drills.push_back('{"E,4\n", 0, NO_FILL, "", 1'b1,
                         cmd_result(mclp_pkg::CMD_ENCODER, 2'd3, 16'sd0)});
      drills.push_back('{"M,1,1000\n", 0, NO_FILL, "", 1'b1,
                         cmd_result(mclp_pkg::CMD_DRIVE, 2'd0, 16'sd1000)});
      drills.push_back('{"M,4,-1000\n", 0, NO_FILL, "", 1'b1,
                         cmd_result(mclp_pkg::CMD_DRIVE, 2'd3, -16'sd1000)});
      drills.push_back('{"M,2,1001\n", 0, NO_FILL, "", 1'b1, err_result(mclp_pkg::ERR_RANGE)});
      drills.push_back('{"M,3,-1001\n", 0, NO_FILL, "", 1'b1, err_result(mclp_pkg::ERR_RANGE)});
      drills.push_back('{"\n", 0, NO_FILL, "", 1'b0, NO_VERDICT});
      drills.push_back('{" \t\015\015 \n", 0, NO_FILL, "", 1'b0, NO_VERDICT});
      drills.push_back('{",,,\n", 0, NO_FILL, "", 1'b1,
                         err_result(mclp_pkg::ERR_BAD_PREFIX)});
      drills.push_back('{"X,1\n", 0, NO_FILL, "", 1'b1,
                         err_result(mclp_pkg::ERR_BAD_PREFIX)});
      drills.push_back('{"stop\n", 0, NO_FILL, "", 1'b1,
                         err_result(mclp_pkg::ERR_BAD_PREFIX)});
      drills.push_back('{"STOP,1\n", 0, NO_FILL, "", 1'b1,
                         err_result(mclp_pkg::ERR_ARG_COUNT)});
      drills.push_back('{"E,0\n", 0, NO_FILL, "", 1'b1,
                         err_result(mclp_pkg::ERR_BAD_CHANNEL)});
      drills.push_back('{"E,5\n", 0, NO_FILL, "", 1'b1,
                         err_result(mclp_pkg::ERR_BAD_CHANNEL)});
      drills.push_back('{"E\n", 0, NO_FILL, "", 1'b1,
                         err_result(mclp_pkg::ERR_BAD_CHANNEL)});
      drills.push_back('{"M,1\n", 0, NO_FILL, "", 1'b1,
                         err_result(mclp_pkg::ERR_ARG_COUNT)});
      drills.push_back('{"M,1,12a\n", 0, NO_FILL, "", 1'b1,
                         err_result(mclp_pkg::ERR_PARSE_INT)});
      drills.push_back('{"M,1,+\n", 0, NO_FILL, "", 1'b1,
                         err_result(mclp_pkg::ERR_PARSE_INT)});
      drills.push_back('{"M,1,5,6\n", 0, NO_FILL, "", 1'b1,
                         err_result(mclp_pkg::ERR_ARG_COUNT)});
      drills.push_back('{"M,2,99999999\n", 0, NO_FILL, "", 1'b1,
                         err_result(mclp_pkg::ERR_RANGE)});
      drills.push_back('{",,M,,3,,\013 +12,, \t\015\n", 0, NO_FILL, "", 1'b0, NO_VERDICT});
      drills.push_back('{"E, +2 \t\n", 0, NO_FILL, "", 1'b0, NO_VERDICT});
      // A zero byte cuts the line short; the rest is stored but never read.
      drills.push_back('{"STOP", 1, mclp_pkg::CH_NUL, "garbage,1\n", 1'b0, NO_VERDICT});
      drills.push_back('{"", 70, mclp_pkg::CH_S, "\n", 1'b0, NO_VERDICT});
      drills.push_back('{"M,1,", LINE_BYTES - 5, mclp_pkg::CH_ZERO, "\n", 1'b0, NO_VERDICT});
      drills.push_back('{"E,", 1, 8'hB2, "\n", 1'b1, err_result(mclp_pkg::ERR_BAD_CHANNEL)});

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (drills[i]) begin
         put_text(drills[i].head);
         repeat (drills[i].fill_count) out_line.push_back(drills[i].fill_byte);
         put_text(drills[i].tail);
         send_line(!drills[i].typed);
         if (drills[i].typed) line_verdicts.push_back(drills[i].want);
      end

      write_pwm_limit(mclp_pkg::LIMIT_W'(32767));
      random_phase(200, 1'b0);
      write_pwm_limit('0);
      random_phase(150, 1'b0);

      // Hold the result side for a long stretch while short lines keep coming,
      // so the parser backs up and stalls its input.
      idle_odds = 0;
      hold_cycles = LONG_HOLD;
      repeat (30) begin
         put_text($sformatf("E,%0d\n", $urandom_range(1, 4)));
         send_line(1'b1);
      end
      settle();

      write_pwm_limit(mclp_pkg::LIMIT_W'(1));
      random_phase(150, 1'b0);
      middle_limit = $urandom_range(2, 32766);
      write_pwm_limit(mclp_pkg::LIMIT_W'(middle_limit));
      random_phase(200, 1'b0);
      write_pwm_limit(mclp_pkg::PWM_LIMIT_RESET);
      random_phase(150, 1'b1);

      settle();
      $display("tb: %0d bytes sent, %0d results checked (%0d commands, %0d error reports)",
               bytes_sent, commands_seen + errors_seen, commands_seen, errors_seen);
      $display("tb: pwm limit swept over 0, 1, %0d, 1000 and 32767; %0d-cycle output hold",
               middle_limit, LONG_HOLD);
      if (fault_count == 0) $display("tb: done, clean");
      else $display("tb: done, errors");
      $finish;
   end

endmodule
